// File: hdl/bsd_pkg.sv
`default_nettype none

package bsd_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int KEY_W     = 32;
  localparam int ENTRY_W   = 10;
  localparam int RANGE_W   = 11;
  localparam int OUT_IDX_W = 10;

  localparam int IN_DATA_W  = ENTRY_W + KEY_W + RANGE_W + RANGE_W;
  localparam int OUT_DATA_W = 16;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic                 found;
    logic [OUT_IDX_W-1:0] index;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/bsd_table.sv
`default_nettype none

module bsd_table #(
  parameter int DEPTH = bsd_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [bsd_pkg::KEY_W-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [bsd_pkg::KEY_W-1:0] rd_data
);

  logic [bsd_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/bsd_ctrl.sv
`default_nettype none

module bsd_ctrl #(
  parameter int TABLE_DEPTH = bsd_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [bsd_pkg::KEY_W-1:0]   query,
  input  wire logic [bsd_pkg::RANGE_W-1:0] first,
  input  wire logic [bsd_pkg::RANGE_W-1:0] last,
  output logic                            idle,
  output logic                            rd_en,
  output logic      [IDX_W-1:0]           rd_addr,
  input  wire logic [bsd_pkg::KEY_W-1:0]   rd_data,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output bsd_pkg::res_t                   res
);

  // wide enough for the raw range bounds and the depth itself
  localparam int W = ((IDX_W > bsd_pkg::RANGE_W) ? IDX_W : bsd_pkg::RANGE_W) + 1;
  localparam logic [W-1:0] DMAX = W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  state_t                    state_r;
  logic [IDX_W-1:0]          lo_r;
  logic [IDX_W-1:0]          hi_r;
  logic [IDX_W-1:0]          mid_r;
  logic [bsd_pkg::KEY_W-1:0] q_r;
  bsd_pkg::res_t             res_r;

  // start of a search
  logic [W-1:0]     first_w;
  logic [W-1:0]     last_w;
  logic [W-1:0]     hi_w;
  logic             init_empty;
  logic [IDX_W-1:0] lo_i;
  logic [IDX_W-1:0] hi_i;
  logic [IDX_W:0]   init_sum;

  // one probe
  logic             q_gt;
  logic             q_lt;
  logic             left_empty;
  logic             right_empty;
  logic [IDX_W:0]   left_sum;
  logic [IDX_W:0]   right_sum;
  logic [IDX_W-1:0] mid_m1;
  logic [IDX_W-1:0] mid_p1;
  logic [W-1:0]     mid_w;
  logic             probe_more;

  always_comb begin
    first_w    = {{(W - bsd_pkg::RANGE_W){1'b0}}, first};
    last_w     = {{(W - bsd_pkg::RANGE_W + 1){1'b0}}, last[bsd_pkg::RANGE_W-2:0]};
    hi_w       = (last_w > DMAX) ? DMAX : last_w;
    // sign bit of range_last marks an empty range
    init_empty = last[bsd_pkg::RANGE_W-1] | (first_w > hi_w);
    lo_i       = first_w[IDX_W-1:0];
    hi_i       = hi_w[IDX_W-1:0];
    init_sum   = {1'b0, lo_i} + {1'b0, hi_i};
  end

  always_comb begin
    q_gt        = $signed(q_r) > $signed(rd_data);
    q_lt        = $signed(q_r) < $signed(rd_data);
    left_empty  = (mid_r == lo_r);
    right_empty = (mid_r == hi_r);
    mid_m1      = mid_r - IDX_W'(1);
    mid_p1      = mid_r + IDX_W'(1);
    left_sum    = {1'b0, lo_r} + {1'b0, mid_m1};
    right_sum   = {1'b0, mid_p1} + {1'b0, hi_r};
    mid_w       = {{(W - IDX_W){1'b0}}, mid_r};
    probe_more  = (q_gt & ~left_empty) | (q_lt & ~right_empty);
  end

  // read port: first midpoint on start, next midpoint while probing
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = init_sum[IDX_W:1];
    unique case (state_r)
      S_IDLE: begin
        rd_en   = start & ~init_empty;
        rd_addr = init_sum[IDX_W:1];
      end
      S_PROBE: begin
        rd_en   = probe_more;
        rd_addr = q_gt ? left_sum[IDX_W:1] : right_sum[IDX_W:1];
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = init_sum[IDX_W:1];
      end
    endcase
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            q_r         <= query;
            lo_r        <= lo_i;
            hi_r        <= hi_i;
            mid_r       <= init_sum[IDX_W:1];
            res_r.found <= 1'b0;
            res_r.index <= '0;
            state_r     <= init_empty ? S_DONE : S_PROBE;
          end
        end
        S_PROBE: begin
          if (q_gt) begin
            hi_r  <= mid_m1;
            mid_r <= left_sum[IDX_W:1];
          end else if (q_lt) begin
            lo_r  <= mid_p1;
            mid_r <= right_sum[IDX_W:1];
          end
          if (!q_gt && !q_lt) begin
            res_r.found <= 1'b1;
            res_r.index <= mid_w[bsd_pkg::OUT_IDX_W-1:0];
          end
          if (!probe_more) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/descending_binary_search.sv
`default_nettype none

// Binary search over a table of signed 32-bit keys that software keeps sorted
// in descending order. An item with in_tuser = 0 writes key_value at
// entry_index (ignored if the index lies beyond the table) and gives no
// result. An item with in_tuser = 1 searches key_value over the
// inclusive range [range_first, range_last], with range_last clipped to the
// last entry and a negative range_last meaning an empty range. The search
// probes the midpoint of the range, goes left when the query is greater than
// the probed key and right when it is smaller, and gives one result item:
// out_tuser = found, out_tdata = matching index (0 when not found). A search
// is accepted, probes the key memory at most floor(log2(range length)) + 1
// times and then hands the result to the output register; the probe loop is
// paced by the single read port of the key memory, whose registered read
// data is compared and the next address chosen in the same cycle. One item
// is in work at a time, but the next item is taken while a result still
// waits in the output register. Table entries are undefined after reset; a
// search must touch only entries already written.
module descending_binary_search #(
  parameter int TABLE_DEPTH = bsd_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [9:0] entry_index, [41:10] key_value, [52:42] range_first, [63:53] range_last
  input  wire logic [bsd_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] kind
  input  wire logic                          in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [9:0] found_index, [15:10] zero
  output logic      [bsd_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] found
  output logic                               out_tuser
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  // wide enough to hold any entry index and the depth itself
  localparam int W = ((IDX_W > bsd_pkg::ENTRY_W) ? IDX_W : bsd_pkg::ENTRY_W) + 1;

  // input field unpacking
  logic [bsd_pkg::ENTRY_W-1:0] entry_index;
  logic [bsd_pkg::KEY_W-1:0]   key_value;
  logic [bsd_pkg::RANGE_W-1:0] range_first;
  logic [bsd_pkg::RANGE_W-1:0] range_last;

  assign entry_index = in_tdata[bsd_pkg::ENTRY_W-1:0];
  assign key_value   = in_tdata[bsd_pkg::ENTRY_W +: bsd_pkg::KEY_W];
  assign range_first = in_tdata[bsd_pkg::ENTRY_W + bsd_pkg::KEY_W +: bsd_pkg::RANGE_W];
  assign range_last  = in_tdata[bsd_pkg::ENTRY_W + bsd_pkg::KEY_W + bsd_pkg::RANGE_W +:
                                bsd_pkg::RANGE_W];

  logic in_accept;
  logic ctrl_idle;

  assign in_tready = ctrl_idle;
  assign in_accept = in_tvalid & ctrl_idle;

  // write path: index outside the table drops the item
  logic [W-1:0] wr_idx_w;
  logic         wr_en;
  logic         start;

  assign wr_idx_w = {{(W - bsd_pkg::ENTRY_W){1'b0}}, entry_index};
  assign wr_en    = in_accept & (in_tuser == bsd_pkg::KIND_WRITE) &
                    (wr_idx_w < W'(TABLE_DEPTH));
  assign start    = in_accept & (in_tuser == bsd_pkg::KIND_SEARCH);

  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic [bsd_pkg::KEY_W-1:0] rd_data;
  logic                      res_valid;
  logic                      res_ready;
  bsd_pkg::res_t             res;

  bsd_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_w[IDX_W-1:0]),
    .wr_data (key_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bsd_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .query     (key_value),
    .first     (range_first),
    .last      (range_last),
    .idle      (ctrl_idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: frees the search engine as soon as a result is parked
  logic          out_valid_r;
  bsd_pkg::res_t out_res_r;

  assign res_ready = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.found;
  assign out_tdata  = {{(bsd_pkg::OUT_DATA_W - bsd_pkg::OUT_IDX_W){1'b0}}, out_res_r.index};

endmodule

`default_nettype wire
